// ===== src/sfs_pkg.sv =====
// Shared constants and register indexes for the sprite frame sequencer.
// No dependencies; imported by every module of the block.
`default_nettype none

package sfs_pkg;

  localparam int unsigned TICK_W     = 16;
  localparam int unsigned FPS_W      = 16;
  localparam int unsigned ELAPSED_W  = 32;
  localparam int unsigned PROD_W     = ELAPSED_W + FPS_W;
  localparam int unsigned STEP_LSB   = 24;
  localparam int unsigned STEP_W     = PROD_W - STEP_LSB;
  localparam int unsigned DIM_W      = 7;
  localparam int unsigned TOTAL_W    = 13;
  localparam int unsigned FRAME_W    = 12;
  localparam int unsigned COL_W      = 6;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned COORD_W    = FRAC_W + 1;

  localparam int unsigned GRID_MAX   = 64;
  localparam int unsigned FRAMES_MAX = 4096;
  localparam logic [COORD_W-1:0] COORD_ONE = COORD_W'(1) << FRAC_W;

  localparam int unsigned IN_DATA_W     = 16;
  localparam int unsigned OUT_FIELDS_W  = FRAME_W + COL_W + FRAME_W + 4 * COORD_W;
  localparam int unsigned OUT_DATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W     = OUT_DATA_W - OUT_FIELDS_W;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_GRID_COLUMNS = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_GRID_ROWS    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_TOTAL  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_FPS          = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_PLAY         = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_LOOP         = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_PINGPONG     = 3'd6;

endpackage

`default_nettype wire

// ===== src/sfs_mul.sv =====
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Uses sfs_pkg.
`default_nettype none

module sfs_mul #(
  parameter int unsigned AW = 32,
  parameter int unsigned BW = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [AW-1:0]    a_i,
  input  wire logic [BW-1:0]    b_i,
  output logic      [AW+BW-1:0] prod_o,
  output logic                  done_o
);
  import sfs_pkg::*;

  localparam int unsigned CW = $clog2(BW + 1);

  logic [AW+BW-1:0] p_q, p_d;
  logic [AW-1:0]    a_q;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [AW:0]      sum;

  always_comb begin
    sum    = {1'b0, p_q[AW+BW-1:BW]} + (p_q[0] ? {1'b0, a_q} : '0);
    p_d    = p_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = busy_q && (cnt_q == CW'(1));
    if (start_i) begin
      p_d    = {{AW{1'b0}}, b_i};
      cnt_d  = CW'(BW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      p_d   = {sum, p_q[BW-1:1]};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
    if (start_i) begin
      a_q <= a_i;
    end
  end

  assign prod_o = p_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

// ===== src/sfs_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Remainder may be preloaded (must be below the divisor). Uses sfs_pkg.
`default_nettype none

module sfs_div #(
  parameter int unsigned QW = 12,
  parameter int unsigned DW = 7
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [QW-1:0] dividend_i,
  input  wire logic [DW-1:0] divisor_i,
  input  wire logic [DW-1:0] rem_init_i,
  output logic      [QW-1:0] quot_o,
  output logic      [DW-1:0] rem_o,
  output logic               done_o
);
  import sfs_pkg::*;

  localparam int unsigned CW = $clog2(QW + 1);

  logic [QW-1:0] q_q, q_d;
  logic [DW-1:0] r_q, r_d;
  logic [DW-1:0] d_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  always_comb begin
    trial  = {r_q, q_q[QW-1]};
    ge     = trial >= {1'b0, d_q};
    diff   = trial - {1'b0, d_q};
    q_d    = q_q;
    r_d    = r_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = busy_q && (cnt_q == CW'(1));
    if (start_i) begin
      q_d    = dividend_i;
      r_d    = rem_init_i;
      cnt_d  = CW'(QW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      q_d   = {q_q[QW-2:0], ge};
      r_d   = ge ? diff[DW-1:0] : trial[DW-1:0];
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
    r_q <= r_d;
    if (start_i) begin
      d_q <= divisor_i;
    end
  end

  assign quot_o = q_q;
  assign rem_o  = r_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

// ===== src/sprite_frame_sequencer_top.sv =====
// One tick word in flight; the next is taken once the result is in the output register.
// A held frame passes through the 12-step column divider and the four 16-step coordinate
// dividers that run in parallel; one-shot mode adds the 16-step serial multiplier before
// them, and loop or ping-pong mode also the 24-step modulo divider after the multiplier.
// A result waits in the output register while the next tick runs; if still held, it stalls.
// Reset: async active low; grid 1x1, other registers, elapsed time and frame zero.
`default_nettype none

module sprite_frame_sequencer_top (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [sfs_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  wire logic [sfs_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  wire logic [sfs_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,  // [15:0] tick_duration
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  // [11:0] frame_index, [17:12] cell_column, [29:18] cell_row, [46:30] coord_u_start,
  // [63:47] coord_v_start, [80:64] coord_u_end, [97:81] coord_v_end, [103:98] zero
  output logic      [sfs_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o
);
  import sfs_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_MOD  = 6'b000100,
    ST_DIV  = 6'b001000,
    ST_CRD  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_e;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(GRID_MAX)) begin
      r = DIM_W'(GRID_MAX);
    end
    return r;
  endfunction

  state_e state_q, state_d;

  logic [DIM_W-1:0]   gcol_q, grow_q;
  logic [TOTAL_W-1:0] ftot_q;
  logic [FPS_W-1:0]   fps_q;
  logic               play_q, loop_q, pp_q;

  logic [ELAPSED_W-1:0] elapsed_q, elapsed_d;
  logic [FRAME_W-1:0]   cur_q, cur_d;
  logic [ELAPSED_W:0]   elapsed_sum;

  logic [DIM_W-1:0]     cols, rows;
  logic [2*DIM_W-1:0]   grid_prod;
  logic [TOTAL_W-1:0]   total, period;
  logic [FRAME_W-1:0]   total_m1;
  logic                 advance;
  logic                 accept;

  logic                 mul_start, mul_done;
  logic [PROD_W-1:0]    mul_prod;
  logic [STEP_W-1:0]    step;

  logic                 mod_start, mod_done;
  logic [TOTAL_W-1:0]   mod_rem;
  logic [TOTAL_W-1:0]   bounce;

  logic                 frame_set;
  logic [FRAME_W-1:0]   frame_raw, frame_new;
  logic                 div_done;
  logic [FRAME_W-1:0]   div_quot;
  logic [DIM_W-1:0]     div_rem;

  logic [COL_W-1:0]     col_q;
  logic [FRAME_W-1:0]   row_q;
  logic                 crd_start;
  logic [TOTAL_W-1:0]   crd_num  [4];
  logic [DIM_W-1:0]     crd_den  [4];
  logic [3:0]           crd_sat;
  logic [3:0]           crd_sat_q;
  logic [DIM_W-1:0]     crd_init [4];
  logic [FRAC_W-1:0]    crd_quot [4];
  logic [3:0]           crd_done;
  logic [COORD_W-1:0]   crd_val  [4];

  logic                 out_load;
  logic                 m_valid_q, m_valid_d;
  logic [FRAME_W-1:0]   out_frame_q;
  logic [COL_W-1:0]     out_col_q;
  logic [FRAME_W-1:0]   out_row_q;
  logic [COORD_W-1:0]   out_us_q, out_vs_q, out_ue_q, out_ve_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gcol_q <= DIM_W'(1);
      grow_q <= DIM_W'(1);
      ftot_q <= '0;
      fps_q  <= '0;
      play_q <= 1'b0;
      loop_q <= 1'b0;
      pp_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_GRID_COLUMNS: gcol_q <= cfg_wdata_i[DIM_W-1:0];
        REG_GRID_ROWS:    grow_q <= cfg_wdata_i[DIM_W-1:0];
        REG_FRAME_TOTAL:  ftot_q <= cfg_wdata_i[TOTAL_W-1:0];
        REG_FPS:          fps_q  <= cfg_wdata_i[FPS_W-1:0];
        REG_PLAY:         play_q <= cfg_wdata_i[0];
        REG_LOOP:         loop_q <= cfg_wdata_i[0];
        REG_PINGPONG:     pp_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // derived geometry
  always_comb begin
    cols      = eff_dim(gcol_q);
    rows      = eff_dim(grow_q);
    grid_prod = cols * rows;
    if (ftot_q == '0) begin
      total = grid_prod[TOTAL_W-1:0];
    end else if (ftot_q > TOTAL_W'(FRAMES_MAX)) begin
      total = TOTAL_W'(FRAMES_MAX);
    end else begin
      total = ftot_q;
    end
    total_m1 = FRAME_W'(total - TOTAL_W'(1));
    period   = {total_m1, 1'b0};
    advance  = play_q && (fps_q != '0) && (total > TOTAL_W'(1));
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign elapsed_sum = {1'b0, elapsed_q} + (ELAPSED_W + 1)'(s_axis_tdata_i[TICK_W-1:0]);
  assign step        = mul_prod[PROD_W-1:STEP_LSB];
  assign bounce      = period - mod_rem;

  // sequencer
  always_comb begin
    state_d   = state_q;
    elapsed_d = elapsed_q;
    mul_start = 1'b0;
    mod_start = 1'b0;
    frame_set = 1'b0;
    frame_raw = cur_q;
    crd_start = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (advance) begin
            elapsed_d = elapsed_sum[ELAPSED_W] ? '1 : elapsed_sum[ELAPSED_W-1:0];
            mul_start = 1'b1;
            state_d   = ST_MUL;
          end else begin
            frame_set = 1'b1;
            state_d   = ST_DIV;
          end
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          if (pp_q || loop_q) begin
            mod_start = 1'b1;
            state_d   = ST_MOD;
          end else begin
            frame_raw = (step < STEP_W'(total)) ? step[FRAME_W-1:0] : total_m1;
            frame_set = 1'b1;
            state_d   = ST_DIV;
          end
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          if (pp_q && (mod_rem >= total)) begin
            frame_raw = bounce[FRAME_W-1:0];
          end else begin
            frame_raw = mod_rem[FRAME_W-1:0];
          end
          frame_set = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          crd_start = 1'b1;
          state_d   = ST_CRD;
        end
      end
      ST_CRD: begin
        if (&crd_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!m_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign frame_new = (frame_raw > total_m1) ? total_m1 : frame_raw;
  assign cur_d     = frame_set ? frame_new : cur_q;
  assign m_valid_d = out_load ? 1'b1 : (m_axis_tready_i ? 1'b0 : m_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      elapsed_q <= '0;
      cur_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      elapsed_q <= elapsed_d;
      cur_q     <= cur_d;
      m_valid_q <= m_valid_d;
    end
  end

  sfs_mul #(
    .AW (ELAPSED_W),
    .BW (FPS_W)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (elapsed_d),
    .b_i     (fps_q),
    .prod_o  (mul_prod),
    .done_o  (mul_done)
  );

  sfs_div #(
    .QW (STEP_W),
    .DW (TOTAL_W)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (step),
    .divisor_i  (pp_q ? period : total),
    .rem_init_i ('0),
    .quot_o     (),
    .rem_o      (mod_rem),
    .done_o     (mod_done)
  );

  sfs_div #(
    .QW (FRAME_W),
    .DW (DIM_W)
  ) u_cell (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (frame_set),
    .dividend_i (frame_new),
    .divisor_i  (cols),
    .rem_init_i ('0),
    .quot_o     (div_quot),
    .rem_o      (div_rem),
    .done_o     (div_done)
  );

  // coordinate lanes: u start, v start, u end, v end
  always_comb begin
    crd_num[0] = TOTAL_W'(div_rem[COL_W-1:0]);
    crd_num[1] = TOTAL_W'(div_quot);
    crd_num[2] = TOTAL_W'(div_rem[COL_W-1:0]) + TOTAL_W'(1);
    crd_num[3] = TOTAL_W'(div_quot) + TOTAL_W'(1);
    crd_den[0] = cols;
    crd_den[1] = rows;
    crd_den[2] = cols;
    crd_den[3] = rows;
  end

  for (genvar i = 0; i < 4; i++) begin : g_crd
    assign crd_sat[i]  = crd_num[i] >= TOTAL_W'(crd_den[i]);
    assign crd_init[i] = crd_sat[i] ? '0 : crd_num[i][DIM_W-1:0];
    assign crd_val[i]  = crd_sat_q[i] ? COORD_ONE : {1'b0, crd_quot[i]};

    sfs_div #(
      .QW (FRAC_W),
      .DW (DIM_W)
    ) u_crd (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .start_i    (crd_start),
      .dividend_i ('0),
      .divisor_i  (crd_den[i]),
      .rem_init_i (crd_init[i]),
      .quot_o     (crd_quot[i]),
      .rem_o      (),
      .done_o     (crd_done[i])
    );
  end

  always_ff @(posedge clk_i) begin
    if (crd_start) begin
      col_q     <= div_rem[COL_W-1:0];
      row_q     <= div_quot;
      crd_sat_q <= crd_sat;
    end
    if (out_load) begin
      out_frame_q <= cur_q;
      out_col_q   <= col_q;
      out_row_q   <= row_q;
      out_us_q    <= crd_val[0];
      out_vs_q    <= crd_val[1];
      out_ue_q    <= crd_val[2];
      out_ve_q    <= crd_val[3];
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {{OUT_PAD_W{1'b0}}, out_ve_q, out_ue_q, out_vs_q, out_us_q,
                            out_row_q, out_col_q, out_frame_q};

`ifndef SYNTH
  a_elapsed_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    elapsed_q >= $past(elapsed_q))
    else $error("elapsed time decreased");

  a_idle_frame_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && (state_q == ST_IDLE)) |-> (out_frame_q == cur_q))
    else $error("pending frame differs from stored frame");

  a_coord_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> ((out_us_q <= out_ue_q) && (out_vs_q <= out_ve_q)))
    else $error("texture coordinates out of order");
`endif

endmodule

`default_nettype wire

// ===== tb/sprite_frame_checker.sv =====
`timescale 1ns / 100ps
// Checker for sprite_frame_sequencer_top: tracks register writes, predicts the frame and
// cell of every accepted tick word and compares each result word in order.
// Depends on sfs_pkg for widths and register indexes.

module sprite_frame_checker (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [sfs_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [sfs_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                           tick_valid_i,
  input  wire logic                           tick_ready_i,
  input  wire logic [sfs_pkg::IN_DATA_W-1:0]  tick_data_i,   // [15:0] tick_duration
  input  wire logic                           cell_valid_i,
  input  wire logic                           cell_ready_i,
  // [11:0] frame_index, [17:12] cell_column, [29:18] cell_row, [46:30] coord_u_start,
  // [63:47] coord_v_start, [80:64] coord_u_end, [97:81] coord_v_end, [103:98] zero
  input  wire logic [sfs_pkg::OUT_DATA_W-1:0] cell_data_i,
  output int unsigned                         mismatches_o,
  output int unsigned                         pending_o
);
  import sfs_pkg::*;

  localparam int unsigned COL_LSB = FRAME_W;
  localparam int unsigned ROW_LSB = COL_LSB + COL_W;
  localparam int unsigned US_LSB  = ROW_LSB + FRAME_W;
  localparam int unsigned VS_LSB  = US_LSB + COORD_W;
  localparam int unsigned UE_LSB  = VS_LSB + COORD_W;
  localparam int unsigned VE_LSB  = UE_LSB + COORD_W;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_index;
    logic [COL_W-1:0]   cell_column;
    logic [FRAME_W-1:0] cell_row;
    logic [COORD_W-1:0] u_start;
    logic [COORD_W-1:0] v_start;
    logic [COORD_W-1:0] u_end;
    logic [COORD_W-1:0] v_end;
  } sprite_cell_t;

  sprite_cell_t expected_cells[$];
  int unsigned  mismatch_cnt;

  logic [DIM_W-1:0]     grid_cols;
  logic [DIM_W-1:0]     grid_rows;
  logic [TOTAL_W-1:0]   frame_cnt;
  logic [FPS_W-1:0]     fps_q8;
  logic                 play_on;
  logic                 loop_on;
  logic                 pingpong_on;
  logic [ELAPSED_W-1:0] elapsed_q16;
  logic [FRAME_W-1:0]   held_frame;

  function automatic int unsigned dim_eff(logic [DIM_W-1:0] v);
    if (v == '0) return 1;
    if (v > GRID_MAX) return GRID_MAX;
    return v;
  endfunction

  function automatic logic [COORD_W-1:0] coord_q16(int unsigned num, int unsigned den);
    longint unsigned c;
    c = (64'(num) << FRAC_W) / 64'(den);
    if (c > 64'(COORD_ONE)) c = 64'(COORD_ONE);
    return COORD_W'(c);
  endfunction

  task automatic predict_frame(input logic [TICK_W-1:0] tick, output sprite_cell_t pred);
    int unsigned     cols, rows, total, frame, col, row;
    longint unsigned sum, step, period, p;
    cols  = dim_eff(grid_cols);
    rows  = dim_eff(grid_rows);
    total = (frame_cnt != '0) ? frame_cnt : cols * rows;
    if (total > FRAMES_MAX) total = FRAMES_MAX;
    if (total < 1) total = 1;
    frame = held_frame;
    if (play_on && fps_q8 != '0 && total > 1) begin
      sum = 64'(elapsed_q16) + 64'(tick);
      elapsed_q16 = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[ELAPSED_W-1:0];
      step = (64'(elapsed_q16) * 64'(fps_q8)) >> STEP_LSB;
      if (pingpong_on) begin
        period = 64'(2 * (total - 1));
        p      = step % period;
        frame  = (p < 64'(total)) ? 32'(p) : 32'(period - p);
      end else if (loop_on) begin
        frame = 32'(step % 64'(total));
      end else begin
        frame = (step < 64'(total)) ? 32'(step) : total - 1;
      end
    end
    if (frame > total - 1) frame = total - 1;
    held_frame = frame[FRAME_W-1:0];
    col = held_frame % cols;
    row = held_frame / cols;
    pred.frame_index = held_frame;
    pred.cell_column = col[COL_W-1:0];
    pred.cell_row    = row[FRAME_W-1:0];
    pred.u_start     = coord_q16(col, cols);
    pred.v_start     = coord_q16(row, rows);
    pred.u_end       = coord_q16(col + 1, cols);
    pred.v_end       = coord_q16(row + 1, rows);
  endtask

  task automatic check_field(input string name, input longint unsigned exp_v,
                             input longint unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    sprite_cell_t exp_c;
    sprite_cell_t new_c;
    if (!rst_ni) begin
      grid_cols    = 7'd1;
      grid_rows    = 7'd1;
      frame_cnt    = '0;
      fps_q8       = '0;
      play_on      = 1'b0;
      loop_on      = 1'b0;
      pingpong_on  = 1'b0;
      elapsed_q16  = '0;
      held_frame   = '0;
      mismatch_cnt = 0;
      expected_cells.delete();
      mismatches_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_GRID_COLUMNS: grid_cols   = cfg_wdata_i[DIM_W-1:0];
          REG_GRID_ROWS:    grid_rows   = cfg_wdata_i[DIM_W-1:0];
          REG_FRAME_TOTAL:  frame_cnt   = cfg_wdata_i[TOTAL_W-1:0];
          REG_FPS:          fps_q8      = cfg_wdata_i[FPS_W-1:0];
          REG_PLAY:         play_on     = cfg_wdata_i[0];
          REG_LOOP:         loop_on     = cfg_wdata_i[0];
          REG_PINGPONG:     pingpong_on = cfg_wdata_i[0];
          default: ;
        endcase
      end
      // result first: a word leaving now belongs to an older tick
      if (cell_valid_i && cell_ready_i) begin
        if (expected_cells.size() == 0) begin
          $error("result word with no tick outstanding");
          mismatch_cnt++;
        end else begin
          exp_c = expected_cells.pop_front();
          check_field("frame_index", exp_c.frame_index, cell_data_i[0 +: FRAME_W]);
          check_field("cell_column", exp_c.cell_column, cell_data_i[COL_LSB +: COL_W]);
          check_field("cell_row", exp_c.cell_row, cell_data_i[ROW_LSB +: FRAME_W]);
          check_field("coord_u_start", exp_c.u_start, cell_data_i[US_LSB +: COORD_W]);
          check_field("coord_v_start", exp_c.v_start, cell_data_i[VS_LSB +: COORD_W]);
          check_field("coord_u_end", exp_c.u_end, cell_data_i[UE_LSB +: COORD_W]);
          check_field("coord_v_end", exp_c.v_end, cell_data_i[VE_LSB +: COORD_W]);
          check_field("pad", 0, cell_data_i[OUT_DATA_W-1 -: OUT_PAD_W]);
        end
      end
      if (tick_valid_i && tick_ready_i) begin
        predict_frame(tick_data_i[TICK_W-1:0], new_c);
        expected_cells.insert(expected_cells.size(), new_c);
      end
      mismatches_o <= mismatch_cnt;
      pending_o    <= expected_cells.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Top of the sprite_frame_sequencer_top bench: clock, reset, register phases, bursty tick
// stimulus and an output stall pattern; sprite_frame_checker does the predicting.
// Depends on sfs_pkg, the block and tb/sprite_frame_checker.sv.

module testbench;
  import sfs_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 3'd7;
  localparam int unsigned TICK_TARGET = 1850;
  localparam int unsigned HOLD_CYCLES = 2500;

  typedef enum int unsigned { SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_PERIODIC } sink_mode_e;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned n_ticks    = 0;
  int unsigned n_settings = 0;
  bit          long_hold_req = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sprite_frame_sequencer_top dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  sprite_frame_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_addr_i   (cfg_addr),
    .cfg_wdata_i  (cfg_wdata),
    .tick_valid_i (s_tvalid),
    .tick_ready_i (s_tready),
    .tick_data_i  (s_tdata),
    .cell_valid_i (m_tvalid),
    .cell_ready_i (m_tready),
    .cell_data_i  (m_tdata),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  task automatic drain();
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // unused upper bits carry noise
  function automatic logic [CFG_DATA_W-1:0] with_junk(int unsigned val, int unsigned w);
    return (CFG_DATA_W'($urandom) << w) | CFG_DATA_W'(val);
  endfunction

  task automatic apply_setting(input int unsigned cols, input int unsigned rows,
                               input int unsigned total, input int unsigned fps,
                               input bit play, input bit loop_b, input bit pp);
    drain();
    write_reg(REG_GRID_COLUMNS, with_junk(cols, DIM_W));
    write_reg(REG_GRID_ROWS, with_junk(rows, DIM_W));
    write_reg(REG_FRAME_TOTAL, with_junk(total, TOTAL_W));
    write_reg(REG_FPS, with_junk(fps, FPS_W));
    write_reg(REG_PLAY, with_junk(play, 1));
    write_reg(REG_LOOP, with_junk(loop_b, 1));
    write_reg(REG_PINGPONG, with_junk(pp, 1));
    n_settings++;
  endtask

  task automatic send_tick(input logic [TICK_W-1:0] val);
    s_tvalid <= 1'b1;
    s_tdata  <= val;
    do @(posedge clk); while (!s_tready);
    n_ticks++;
  endtask

  function automatic logic [TICK_W-1:0] pick_tick(int unsigned cap);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 16'hFFFF;
      2:       return TICK_W'(1) << $urandom_range(0, TICK_W - 1);
      default: return TICK_W'($urandom_range(0, cap));
    endcase
  endfunction

  function automatic int unsigned pick_dim();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 1;
      2:       return GRID_MAX;
      3:       return $urandom_range(GRID_MAX + 1, 127);
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  task automatic play_ticks(input int count, input int unsigned cap, input bit gaps_on);
    int burst_left;
    int gap;
    burst_left = $urandom_range(1, 12);
    for (int k = 0; k < count; k++) begin
      send_tick(pick_tick(cap));
      burst_left--;
      if (burst_left == 0 && gaps_on && k != count - 1) begin
        burst_left = $urandom_range(1, 12);
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: gap = $urandom_range(0, 3);
          6, 7, 8:          gap = $urandom_range(4, 40);
          default:          gap = $urandom_range(41, 150);
        endcase
        if (gap > 0) begin
          s_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    s_tvalid <= 1'b0;
  endtask

  // output side: stall pattern of its own, plus one long hold on request
  initial begin : sink
    sink_mode_e  mode;
    int unsigned mode_left;
    int unsigned cyc;
    int unsigned stall_cnt;
    mode      = SINK_OPEN;
    mode_left = 0;
    cyc       = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        m_tready <= 1'b0;
        for (stall_cnt = 0; stall_cnt < HOLD_CYCLES; stall_cnt++) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          mode      = sink_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 300);
        end
        mode_left--;
        case (mode)
          SINK_OPEN:     m_tready <= 1'b1;
          SINK_COIN:     m_tready <= 1'($urandom_range(0, 1));
          SINK_SPARSE:   m_tready <= ($urandom_range(0, 7) == 0);
          SINK_PERIODIC: m_tready <= cyc[3];
          default:       m_tready <= 1'b1;
        endcase
      end
    end
  end

  initial begin : watchdog
    #20_000_000;
    $display("sprite_frame_sequencer_top verification failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned n_phase;
    int unsigned r_total;
    int unsigned r_fps;
    int unsigned r_cap;
    n_phase = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // reset defaults: single-frame sheet, nothing advances
    send_tick(16'h0000);
    send_tick(16'hFFFF);
    s_tvalid <= 1'b0;
    // zero rate holds the frame
    apply_setting(4, 2, 40, 0, 1'b1, 1'b0, 1'b0);
    send_tick(16'h1234);
    s_tvalid <= 1'b0;
    // one-shot runs past the grid rows and parks on the last frame
    apply_setting(4, 2, 40, 16'h1000, 1'b1, 1'b0, 1'b0);
    send_tick(16'hFFFF);
    send_tick(16'hFFFF);
    send_tick(16'hFFFF);
    s_tvalid <= 1'b0;
    // ping-pong wins over loop
    apply_setting(4, 2, 40, 16'h1000, 1'b1, 1'b1, 1'b1);
    send_tick(16'h8000);
    send_tick(16'hFFFF);
    send_tick(16'h4321);
    s_tvalid <= 1'b0;
    apply_setting(4, 2, 40, 16'h1000, 1'b1, 1'b1, 1'b0);
    send_tick(16'hFFFF);
    send_tick(16'h0001);
    s_tvalid <= 1'b0;
    // paused with a smaller count: held frame clamps down
    apply_setting(4, 2, 5, 16'h1000, 1'b0, 1'b0, 1'b0);
    send_tick(16'hFFFF);
    s_tvalid <= 1'b0;
    // zero dims and zero count give one frame
    apply_setting(0, 0, 0, 16'hFFFF, 1'b1, 1'b1, 1'b0);
    send_tick(16'hFFFF);
    s_tvalid <= 1'b0;
    // oversized grid and count, plus a write to the unused index
    apply_setting(127, 100, 8191, 16'hFFFF, 1'b1, 1'b1, 1'b0);
    write_reg(REG_UNUSED, 16'hFFFF);
    send_tick(16'hFFFF);
    send_tick(16'hFFFF);
    send_tick(16'hFFFF);
    s_tvalid <= 1'b0;
    apply_setting(64, 64, 0, 16'hFFFF, 1'b1, 1'b0, 1'b1);
    send_tick(16'hFFFF);
    send_tick(16'h7FFF);
    s_tvalid <= 1'b0;
    apply_setting(64, 64, FRAMES_MAX, 16'h0001, 1'b1, 1'b0, 1'b0);
    send_tick(16'h0000);
    s_tvalid <= 1'b0;
    apply_setting(1, 64, 0, 16'hFFFF, 1'b1, 1'b1, 1'b0);
    send_tick(16'hFFFF);
    send_tick(16'hAAAA);
    s_tvalid <= 1'b0;

    while (n_ticks < TICK_TARGET) begin
      n_phase++;
      case ($urandom_range(0, 5))
        0:       r_total = 0;
        1:       r_total = $urandom_range(1, 3);
        2:       r_total = $urandom_range(FRAMES_MAX + 1, 8191);
        3:       r_total = FRAMES_MAX;
        default: r_total = $urandom_range(1, 80);
      endcase
      case ($urandom_range(0, 5))
        0:       r_fps = 0;
        1:       r_fps = 16'hFFFF;
        2:       r_fps = $urandom_range(1, 16'h0400);
        default: r_fps = $urandom_range(0, 16'hFFFF);
      endcase
      case ($urandom_range(0, 2))
        0:       r_cap = 255;
        1:       r_cap = 4095;
        default: r_cap = 16'hFFFF;
      endcase
      apply_setting(pick_dim(), pick_dim(), r_total, r_fps, $urandom_range(0, 4) != 0,
                    1'($urandom_range(0, 1)), $urandom_range(0, 2) == 0);
      if ($urandom_range(0, 5) == 0) write_reg(REG_UNUSED, 16'($urandom));
      if (n_phase == 8) long_hold_req = 1'b1;
      play_ticks($urandom_range(20, 60), r_cap, (n_phase % 6 != 0) && (n_phase != 8));
    end

    drain();
    repeat (100) @(posedge clk);
    $display("%0d tick words over %0d register settings, with bursts, gaps and output stalls",
             n_ticks, n_settings);
    if (mismatches == 0 && pending == 0) begin
      $display("sprite_frame_sequencer_top verification clean");
    end else begin
      $display("sprite_frame_sequencer_top verification failed");
    end
    $finish;
  end

endmodule
